/* src/mmb_pkg.sv */
// Package for the Morse message beacon: sizes, reset values and the
// character-to-unit-pattern lookup. No dependencies.
package mmb_pkg;

   localparam int MSG_DEPTH = 32;
   localparam int IDX_W     = $clog2(MSG_DEPTH);
   localparam int NEXT_W    = IDX_W + 1;
   localparam int CHAR_W    = 8;
   localparam int SLOT_W    = 5;
   localparam int DIV_W     = 8;
   localparam int PAT_W     = 22;
   localparam int POS_W     = 5;

   // Item kinds carried in the action field.
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   localparam logic [DIV_W-1:0]  UNIT_DIVIDE_RESET = 8'd20;
   localparam logic [POS_W-1:0]  END_UNITS         = 5'd7;
   localparam logic [POS_W-1:0]  SPACE_UNITS       = 5'd4;
   localparam logic [CHAR_W-1:0] CHAR_NUL          = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE        = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO         = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE         = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A      = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z      = 8'h5a;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A      = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z      = 8'h7a;
   localparam logic [CHAR_W-1:0] CASE_OFFSET       = 8'h20;

   localparam logic [NEXT_W-1:0] DEPTH_LIMIT = NEXT_W'(MSG_DEPTH);

   // Patterns are sent LSB first and include the trailing letter gap.
   localparam logic [PAT_W-1:0] ALPHA_BITS [26] = '{
      22'h1D, 22'h157, 22'h5D7, 22'h57, 22'h1, 22'h175, 22'h177, 22'h55, 22'h5,
      22'h1DDD, 22'h1D7, 22'h15D, 22'h77, 22'h17, 22'h777, 22'h5DD, 22'h1D77,
      22'h5D, 22'h15, 22'h7, 22'h75, 22'h1D5, 22'h1DD, 22'h757, 22'h1DD7, 22'h577
   };
   localparam logic [POS_W-1:0] ALPHA_LEN [26] = '{
      5'd8, 5'd12, 5'd14, 5'd10, 5'd4, 5'd12, 5'd12, 5'd10, 5'd6, 5'd16, 5'd12,
      5'd12, 5'd10, 5'd8, 5'd14, 5'd14, 5'd16, 5'd10, 5'd8, 5'd6, 5'd10, 5'd12,
      5'd12, 5'd14, 5'd16, 5'd14
   };
   localparam logic [PAT_W-1:0] DIGIT_BITS [10] = '{
      22'h77777, 22'h1DDDD, 22'h7775, 22'h1DD5, 22'h755, 22'h155, 22'h557,
      22'h1577, 22'h5777, 22'h17777
   };
   localparam logic [POS_W-1:0] DIGIT_LEN [10] = '{
      5'd22, 5'd20, 5'd18, 5'd16, 5'd14, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20
   };

   typedef struct packed {
      logic [PAT_W-1:0] bits;
      logic [POS_W-1:0] len;
   } pattern_type;

   function automatic pattern_type pattern_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      pattern_type       p;
      u = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         u = c - CASE_OFFSET;
      end
      if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
         p.bits = ALPHA_BITS[5'(u - CHAR_UPPER_A)];
         p.len  = ALPHA_LEN[5'(u - CHAR_UPPER_A)];
      end else if (u >= CHAR_ZERO && u <= CHAR_NINE) begin
         p.bits = DIGIT_BITS[4'(u - CHAR_ZERO)];
         p.len  = DIGIT_LEN[4'(u - CHAR_ZERO)];
      end else if (u == CHAR_NUL) begin
         // The end marker: one on unit and six off units.
         p.bits = PAT_W'(1);
         p.len  = END_UNITS;
      end else begin
         p.bits = '0;
         p.len  = SPACE_UNITS;
      end
      return p;
   endfunction

endpackage

/* src/mmb_req_if.sv */
// Input channel of the Morse message beacon: valid/ready with one item.
// Depends on mmb_pkg for the field widths.
interface mmb_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [mmb_pkg::SLOT_W-1:0]   char_index;
   logic [mmb_pkg::CHAR_W-1:0]   char_code;

   modport source (output valid, output action, output char_index, output char_code,
                   input ready);
   modport sink   (input valid, input action, input char_index, input char_code,
                   output ready);
endinterface

/* src/mmb_rsp_if.sv */
// Result channel of the Morse message beacon: valid/ready with one Morse unit.
// No dependencies.
interface mmb_rsp_if;
   logic valid;
   logic ready;
   logic led_on;
   logic end_marker;

   modport source (output valid, output led_on, output end_marker, input ready);
   modport sink   (input valid, input led_on, input end_marker, output ready);
endinterface

/* src/morse_message_beacon.sv */
// Morse message beacon: sends the stored message as Morse units, repeating.
// A fired unit is registered into the main entry that drives rsp, or into the skid entry.
// Throughput: one item per cycle; a two-entry output buffer keeps req open
// while a result waits, so req stalls only when both entries are full.
// Reset (synchronous) clears the message store, sets unit_divide
// to 20, clears the tick divider and starts with a four-unit silence.
// Uses mmb_pkg, mmb_*_if.
module morse_message_beacon (
   input  logic                        clock,
   input  logic                        reset,
   mmb_req_if.sink                     req_ch,
   mmb_rsp_if.source                   rsp_ch,
   input  logic                        csr_write_enable,
   input  logic [mmb_pkg::DIV_W-1:0]   csr_write_data
);

   logic [mmb_pkg::CHAR_W-1:0] store_ff [mmb_pkg::MSG_DEPTH];
   logic [mmb_pkg::IDX_W-1:0]  index_ff, index_in;
   logic                       marker_ff, marker_in;
   logic [mmb_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [mmb_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [mmb_pkg::DIV_W-1:0]  div_ff, div_in;
   logic [mmb_pkg::DIV_W-1:0]  unit_divide_ff;

   logic main_valid_ff, main_valid_in, main_led_ff, main_led_in, main_end_ff, main_end_in;
   logic skid_valid_ff, skid_valid_in, skid_led_ff, skid_led_in, skid_end_ff, skid_end_in;

   logic                        accept, load, fire, unit_led, last_unit, end_next;
   mmb_pkg::pattern_type        pattern;
   logic [mmb_pkg::NEXT_W-1:0]  next_index;
   logic [mmb_pkg::CHAR_W-1:0]  next_char;
   logic [mmb_pkg::PAT_W-1:0]   shifted;

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign load         = accept && (req_ch.action == mmb_pkg::ACT_LOAD);
   assign fire         = accept && (req_ch.action == mmb_pkg::ACT_TICK)
                         && (div_ff == unit_divide_ff);

   always_comb begin
      pattern    = mmb_pkg::pattern_of(char_ff);
      shifted    = pattern.bits >> pos_ff;
      unit_led   = shifted[0];
      last_unit  = ({1'b0, pos_ff} + 6'd1) >= {1'b0, pattern.len};
      next_index = marker_ff ? '0 : ({1'b0, index_ff} + mmb_pkg::NEXT_W'(1));
      next_char  = store_ff[next_index[mmb_pkg::IDX_W-1:0]];
      end_next   = (next_index >= mmb_pkg::DEPTH_LIMIT) || (next_char == mmb_pkg::CHAR_NUL);
   end

   always_comb begin
      index_in  = index_ff;
      marker_in = marker_ff;
      char_in   = char_ff;
      pos_in    = pos_ff;
      div_in    = div_ff;
      if (accept && (req_ch.action == mmb_pkg::ACT_TICK)) begin
         if (fire) begin
            div_in = '0;
            if (last_unit) begin
               pos_in = '0;
               if (end_next) begin
                  marker_in = 1'b1;
                  index_in  = '0;
                  char_in   = mmb_pkg::CHAR_NUL;
               end else begin
                  marker_in = 1'b0;
                  index_in  = next_index[mmb_pkg::IDX_W-1:0];
                  char_in   = next_char;
               end
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end else begin
            div_in = div_ff + 8'd1;
         end
      end
   end

   // The main entry drives rsp; the skid entry catches a unit fired while
   // the main entry is stalled.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_led_in   = main_led_ff;
      main_end_in   = main_end_ff;
      skid_valid_in = skid_valid_ff;
      skid_led_in   = skid_led_ff;
      skid_end_in   = skid_end_ff;
      if (!main_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_led_in   = skid_led_ff;
            main_end_in   = skid_end_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = fire;
            main_led_in   = unit_led;
            main_end_in   = marker_ff;
         end
      end else if (fire) begin
         skid_valid_in = 1'b1;
         skid_led_in   = unit_led;
         skid_end_in   = marker_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mmb_pkg::MSG_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
         index_ff       <= '0;
         marker_ff      <= 1'b0;
         char_ff        <= mmb_pkg::CHAR_SPACE;
         pos_ff         <= '0;
         div_ff         <= '0;
         unit_divide_ff <= mmb_pkg::UNIT_DIVIDE_RESET;
         main_valid_ff  <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (load && (32'(req_ch.char_index) < 32'(mmb_pkg::MSG_DEPTH))) begin
            store_ff[mmb_pkg::IDX_W'(req_ch.char_index)] <= req_ch.char_code;
         end
         if (csr_write_enable) begin
            unit_divide_ff <= csr_write_data;
         end
         index_ff      <= index_in;
         marker_ff     <= marker_in;
         char_ff       <= char_in;
         pos_ff        <= pos_in;
         div_ff        <= div_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_led_ff <= main_led_in;
      main_end_ff <= main_end_in;
      skid_led_ff <= skid_led_in;
      skid_end_ff <= skid_end_in;
   end

   assign rsp_ch.valid      = main_valid_ff;
   assign rsp_ch.led_on     = main_led_ff;
   assign rsp_ch.end_marker = main_end_ff;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the Morse message beacon: a table of directed items, then
// random phases at several unit periods. Depends on mmb_pkg, mmb_req_if and mmb_rsp_if.
module tb;

   localparam logic [mmb_pkg::PAT_W-1:0] LETTER_UNITS [26] = '{
      22'h1D, 22'h157, 22'h5D7, 22'h57, 22'h1, 22'h175, 22'h177, 22'h55, 22'h5,
      22'h1DDD, 22'h1D7, 22'h15D, 22'h77, 22'h17, 22'h777, 22'h5DD, 22'h1D77,
      22'h5D, 22'h15, 22'h7, 22'h75, 22'h1D5, 22'h1DD, 22'h757, 22'h1DD7, 22'h577
   };
   localparam logic [mmb_pkg::POS_W-1:0] LETTER_SPAN [26] = '{
      5'd8, 5'd12, 5'd14, 5'd10, 5'd4, 5'd12, 5'd12, 5'd10, 5'd6, 5'd16, 5'd12,
      5'd12, 5'd10, 5'd8, 5'd14, 5'd14, 5'd16, 5'd10, 5'd8, 5'd6, 5'd10, 5'd12,
      5'd12, 5'd14, 5'd16, 5'd14
   };
   localparam logic [mmb_pkg::PAT_W-1:0] NUMERAL_UNITS [10] = '{
      22'h77777, 22'h1DDDD, 22'h7775, 22'h1DD5, 22'h755, 22'h155, 22'h557,
      22'h1577, 22'h5777, 22'h17777
   };
   localparam logic [mmb_pkg::POS_W-1:0] NUMERAL_SPAN [10] = '{
      5'd22, 5'd20, 5'd18, 5'd16, 5'd14, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20
   };

   typedef struct packed {
      logic [mmb_pkg::PAT_W-1:0] bits;
      logic [mmb_pkg::POS_W-1:0] span;
   } morse_shape_type;

   typedef struct packed {
      logic led;
      logic mark;
   } morse_unit_type;

   typedef enum {ROW_TICK, ROW_LOAD, ROW_DIVIDE} row_kind_type;
   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_THIRD, READY_WAVES} stall_mode_type;

   typedef struct {
      row_kind_type kind;
      logic [4:0]   slot;
      logic [7:0]   code;
      int           reps;
      bit           typed;
      logic         led;
      logic         mark;
   } script_row_type;

   // The code field of a divide row carries the new unit_divide value.
   script_row_type script [19] = '{
      '{ROW_TICK,   5'd0,  8'h00, 20, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 1,  1'b1, 1'b0, 1'b0},
      '{ROW_DIVIDE, 5'd0,  8'h00, 1,  1'b0, 1'b0, 1'b0},
      '{ROW_LOAD,   5'd1,  8'h65, 1,  1'b0, 1'b0, 1'b0},
      '{ROW_LOAD,   5'd2,  8'hFF, 1,  1'b0, 1'b0, 1'b0},
      '{ROW_LOAD,   5'd31, 8'h39, 1,  1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 3,  1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 1,  1'b1, 1'b1, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 3,  1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 4,  1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 1,  1'b1, 1'b1, 1'b1},
      '{ROW_TICK,   5'd0,  8'h00, 6,  1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 1,  1'b1, 1'b1, 1'b1},
      '{ROW_LOAD,   5'd0,  8'h5A, 1,  1'b0, 1'b0, 1'b0},
      '{ROW_LOAD,   5'd3,  8'h00, 1,  1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 6,  1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 1,  1'b1, 1'b1, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 13, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,   5'd0,  8'h00, 1,  1'b0, 1'b0, 1'b0}
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [mmb_pkg::DIV_W-1:0]  csr_write_data;

   mmb_req_if req_bus ();
   mmb_rsp_if rsp_bus ();

   morse_message_beacon uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Beacon state as the bench tracks it.
   logic [mmb_pkg::CHAR_W-1:0] msg_mem [mmb_pkg::MSG_DEPTH];
   logic [mmb_pkg::SLOT_W-1:0] send_slot;
   bit                         sending_marker;
   logic [mmb_pkg::CHAR_W-1:0] send_char;
   logic [mmb_pkg::POS_W-1:0]  unit_pos;
   logic [mmb_pkg::DIV_W-1:0]  tick_count;
   logic [mmb_pkg::DIV_W-1:0]  divide_setting;

   morse_unit_type pending_units [$];
   int             units_seen = 0;
   int             mismatch_count = 0;
   int             burst_left = 0;

   // Expectation typed into a table row travels beside the item it belongs to.
   bit          row_typed;
   logic        row_led;
   logic        row_mark;

   stall_mode_type ready_mode = READY_ALWAYS;
   logic [7:0]     ready_cycle = 8'd0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic morse_shape_type morse_shape(input logic [mmb_pkg::CHAR_W-1:0] c);
      logic [mmb_pkg::CHAR_W-1:0] up;
      morse_shape_type            s;
      up = (c >= mmb_pkg::CHAR_LOWER_A && c <= mmb_pkg::CHAR_LOWER_Z)
           ? c - mmb_pkg::CASE_OFFSET : c;
      s.bits = '0;
      s.span = mmb_pkg::SPACE_UNITS;
      if (up >= mmb_pkg::CHAR_UPPER_A && up <= mmb_pkg::CHAR_UPPER_Z) begin
         s.bits = LETTER_UNITS[5'(up - mmb_pkg::CHAR_UPPER_A)];
         s.span = LETTER_SPAN[5'(up - mmb_pkg::CHAR_UPPER_A)];
      end else if (up >= mmb_pkg::CHAR_ZERO && up <= mmb_pkg::CHAR_NINE) begin
         s.bits = NUMERAL_UNITS[4'(up - mmb_pkg::CHAR_ZERO)];
         s.span = NUMERAL_SPAN[4'(up - mmb_pkg::CHAR_ZERO)];
      end else if (up == mmb_pkg::CHAR_NUL) begin
         s.bits = mmb_pkg::PAT_W'(1);
         s.span = mmb_pkg::END_UNITS;
      end
      return s;
   endfunction

   task automatic next_morse_unit(input logic action, input logic [mmb_pkg::SLOT_W-1:0] slot,
                                  input logic [mmb_pkg::CHAR_W-1:0] code, output bit fired,
                                  output morse_unit_type unit);
      morse_shape_type shape;
      logic [5:0]      follow;
      fired = 1'b0;
      unit = '0;
      if (action == mmb_pkg::ACT_LOAD) begin
         if (int'(slot) < mmb_pkg::MSG_DEPTH) msg_mem[slot] = code;
      end else if (tick_count != divide_setting) begin
         tick_count = tick_count + 8'd1;
      end else begin
         tick_count = '0;
         fired = 1'b1;
         shape = morse_shape(send_char);
         unit.led = (unit_pos < 5'd22) ? shape.bits[unit_pos] : 1'b0;
         unit.mark = sending_marker;
         if ({1'b0, unit_pos} + 6'd1 >= {1'b0, shape.span}) begin
            unit_pos = '0;
            follow = sending_marker ? 6'd0 : {1'b0, send_slot} + 6'd1;
            if (follow >= 6'(mmb_pkg::MSG_DEPTH) || msg_mem[follow[4:0]] == mmb_pkg::CHAR_NUL)
            begin
               sending_marker = 1'b1;
               send_slot = '0;
               send_char = mmb_pkg::CHAR_NUL;
            end else begin
               sending_marker = 1'b0;
               send_slot = follow[4:0];
               send_char = msg_mem[follow[4:0]];
            end
         end else begin
            unit_pos = unit_pos + 5'd1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      bit             fired;
      morse_unit_type unit;
      morse_unit_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            next_morse_unit(req_bus.action, req_bus.char_index, req_bus.char_code, fired, unit);
            if (row_typed) pending_units.push_back(morse_unit_type'{row_led, row_mark});
            else if (fired) pending_units.push_back(unit);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            units_seen++;
            if (pending_units.size() == 0) begin
               flag_mismatch("unit sent with none expected");
            end else begin
               want = pending_units.pop_front();
               if (rsp_bus.led_on !== want.led)
                  flag_mismatch($sformatf("led_on %b, expected %b", rsp_bus.led_on, want.led));
               if (rsp_bus.end_marker !== want.mark)
                  flag_mismatch($sformatf("end_marker %b, expected %b",
                                          rsp_bus.end_marker, want.mark));
            end
         end
      end
   end

   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 8'd1;
      if (ready_cycle == 8'd0 || ready_cycle == 8'd128)
         ready_mode <= stall_mode_type'($urandom_range(0, 3));
      case (ready_mode)
         READY_ALWAYS: rsp_bus.ready <= 1'b1;
         READY_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
         READY_THIRD:  rsp_bus.ready <= (ready_cycle % 3 == 0);
         default:      rsp_bus.ready <= ready_cycle[4];
      endcase
   end

   task automatic offer_item(input logic action, input logic [mmb_pkg::SLOT_W-1:0] slot,
                             input logic [mmb_pkg::CHAR_W-1:0] code, input bit typed = 1'b0,
                             input logic led = 1'b0, input logic mark = 1'b0);
      req_bus.valid      <= 1'b1;
      req_bus.action     <= action;
      req_bus.char_index <= slot;
      req_bus.char_code  <= code;
      row_typed          <= typed;
      row_led            <= led;
      row_mark           <= mark;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
      end
   endtask

   task automatic offer_tick();
      offer_item(mmb_pkg::ACT_TICK, mmb_pkg::SLOT_W'($urandom), mmb_pkg::CHAR_W'($urandom));
   endtask

   // Writes happen only once every expected unit is out and the output buffer has settled.
   task automatic set_unit_divide(input logic [mmb_pkg::DIV_W-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_units.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      divide_setting = value;
   endtask

   function automatic logic [mmb_pkg::CHAR_W-1:0] pick_char(input bit quick, input bit allow_end);
      int roll;
      if (quick) begin
         case ($urandom_range(0, 3))
            0:       return 8'h45;
            1:       return 8'h74;
            2:       return 8'h49;
            default: return mmb_pkg::CHAR_SPACE;
         endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return mmb_pkg::CHAR_UPPER_A + mmb_pkg::CHAR_W'($urandom_range(0, 25))
                + (($urandom_range(0, 1) == 1) ? mmb_pkg::CASE_OFFSET : 8'h00);
      if (roll < 55) return mmb_pkg::CHAR_ZERO + mmb_pkg::CHAR_W'($urandom_range(0, 9));
      if (roll < 65) return mmb_pkg::CHAR_SPACE;
      if (roll < 75) return allow_end ? mmb_pkg::CHAR_NUL : mmb_pkg::CHAR_SPACE;
      return mmb_pkg::CHAR_W'($urandom);
   endfunction

   // One random phase: write a message from slot 0, then mostly ticks with stray loads.
   // A quick phase uses only short characters so that a full memory is sent end to end.
   task automatic run_phase(input logic [mmb_pkg::DIV_W-1:0] divide, input int msg_len,
                            input int budget, input int min_units, input bit quick);
      int base;
      int issued;
      set_unit_divide(divide);
      base = units_seen;
      for (int i = 0; i < msg_len; i++)
         offer_item(mmb_pkg::ACT_LOAD, mmb_pkg::SLOT_W'(i), pick_char(quick, 1'b0));
      if (msg_len < mmb_pkg::MSG_DEPTH)
         offer_item(mmb_pkg::ACT_LOAD, mmb_pkg::SLOT_W'(msg_len), mmb_pkg::CHAR_NUL);
      issued = 0;
      while (issued < budget || units_seen - base < min_units) begin
         if ($urandom_range(0, 9) == 0)
            offer_item(mmb_pkg::ACT_LOAD, mmb_pkg::SLOT_W'($urandom), pick_char(quick, 1'b1));
         else
            offer_tick();
         issued++;
      end
   endtask

   initial begin
      int drain_wait;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = mmb_pkg::ACT_TICK;
      req_bus.char_index = '0;
      req_bus.char_code  = '0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      row_typed          = 1'b0;
      row_led            = 1'b0;
      row_mark           = 1'b0;
      foreach (msg_mem[i]) msg_mem[i] = mmb_pkg::CHAR_NUL;
      send_slot      = '0;
      sending_marker = 1'b0;
      send_char      = mmb_pkg::CHAR_SPACE;
      unit_pos       = '0;
      tick_count     = '0;
      divide_setting = mmb_pkg::UNIT_DIVIDE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         case (script[r].kind)
            ROW_DIVIDE: set_unit_divide(script[r].code);
            ROW_LOAD:   offer_item(mmb_pkg::ACT_LOAD, script[r].slot, script[r].code);
            default: begin
               for (int k = 0; k < script[r].reps; k++)
                  offer_item(mmb_pkg::ACT_TICK, mmb_pkg::SLOT_W'($urandom),
                             mmb_pkg::CHAR_W'($urandom),
                             script[r].typed && k == script[r].reps - 1,
                             script[r].led, script[r].mark);
            end
         endcase
      end

      run_phase(8'd0, mmb_pkg::MSG_DEPTH, 0, 180, 1'b1);
      run_phase(8'd1, $urandom_range(1, 8), 40, 12, 1'b0);
      run_phase(mmb_pkg::DIV_W'($urandom_range(2, 6)), $urandom_range(1, 31), 60, 8, 1'b0);
      run_phase(8'd0, $urandom_range(1, 12), 50, 20, 1'b0);

      req_bus.valid <= 1'b0;
      drain_wait = 0;
      while (pending_units.size() != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (pending_units.size() != 0)
         flag_mismatch($sformatf("%0d expected units never sent", pending_units.size()));
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
